[rtl/signed_int_to_decimal_ascii_macros.svh]
// Assertion macros for the signed integer to decimal ASCII block.
// Used by the port checker; relies on clk and rst_n in the including scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SIDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sida_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies.
`default_nettype none

package sida_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int Q_DEPTH        = 2;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;

    // Queue status seen by front and back.
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_SIGN,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

[rtl/sida_front.sv]
// Front end: accepts a command and splits the value into sign and magnitude.
// Depends on sida_pkg.
`default_nettype none

module sida_front #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
    input  wire logic                      start,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire sida_pkg::q_status_t       q_status,
    output logic                           busy,
    output logic                           push,
    output logic                           push_neg,
    output logic [VALUE_BITS-1:0]          push_mag
);

    always_comb
    begin
        busy     = q_status.full;
        push     = start & ~q_status.full;
        push_neg = value[VALUE_BITS-1];
        // Unsigned negate: the most negative value maps to 2^(N-1) exactly.
        push_mag = push_neg ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
    end

endmodule

`default_nettype wire

[rtl/sida_queue.sv]
// Short FIFO of sign/magnitude entries between front and back.
// Depends on sida_pkg.
`default_nettype none

module sida_queue #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic                  push_neg,
    input  wire logic [VALUE_BITS-1:0] push_mag,
    input  wire logic                  pop,
    output sida_pkg::q_status_t        q_status,
    output logic                       head_neg,
    output logic [VALUE_BITS-1:0]      head_mag
);

    localparam int Depth = sida_pkg::Q_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    logic                  neg_reg [Depth];
    logic [VALUE_BITS-1:0] mag_reg [Depth];
    logic [PtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]       count_reg, count_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_comb
    begin
        q_status.not_empty = (count_reg != '0);
        q_status.full      = (count_reg == CntW'(Depth));
        head_neg           = neg_reg[rd_ptr_reg];
        head_mag           = mag_reg[rd_ptr_reg];

        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            neg_reg[wr_ptr_reg] <= push_neg;
            mag_reg[wr_ptr_reg] <= push_mag;
        end
    end

endmodule

`default_nettype wire

[rtl/sida_back.sv]
// Back end: shift-and-add-3 binary to BCD, then character emission.
// Depends on sida_pkg.
`default_nettype none

module sida_back #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF,
    parameter int NUM_DIGITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sida_pkg::q_status_t   q_status,
    input  wire logic                  head_neg,
    input  wire logic [VALUE_BITS-1:0] head_mag,
    output logic                       pop,
    output logic                       strobe,
    output logic [7:0]                 char_code,
    output logic                       last
);

    localparam int BcdW = NUM_DIGITS * 4;
    localparam int CntW = $clog2(VALUE_BITS + 1);

    sida_pkg::back_state_t state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BcdW-1:0]       bcd_reg, bcd_next;
    logic [BcdW-1:0]       bcd_adj;
    logic                  neg_reg, neg_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic                  started_reg, started_next;
    logic                  strobe_reg, strobe_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;
    logic [3:0]            top_digit;
    logic                  final_digit;

    // Add 3 to every digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                            : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = 1'b0;
        pop          = 1'b0;
        top_digit    = bcd_reg[BcdW-1 -: 4];
        final_digit  = (cnt_reg == CntW'(1));

        case (state_reg)
            sida_pkg::BK_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop        = 1'b1;
                    mag_next   = head_mag;
                    neg_next   = head_neg;
                    bcd_next   = '0;
                    cnt_next   = CntW'(VALUE_BITS);
                    state_next = sida_pkg::BK_CONV;
                end
            end
            sida_pkg::BK_CONV:
            begin
                bcd_next     = {bcd_adj[BcdW-2:0], mag_reg[VALUE_BITS-1]};
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next     = cnt_reg - CntW'(1);
                started_next = 1'b0;
                if (final_digit)
                begin
                    cnt_next   = CntW'(NUM_DIGITS);
                    state_next = neg_reg ? sida_pkg::BK_SIGN : sida_pkg::BK_EMIT;
                end
            end
            sida_pkg::BK_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = sida_pkg::CH_MINUS;
                state_next  = sida_pkg::BK_EMIT;
            end
            sida_pkg::BK_EMIT:
            begin
                // Leading zeros are dropped; the units digit always goes out.
                if (started_reg || (top_digit != 4'd0) || final_digit)
                begin
                    strobe_next  = 1'b1;
                    char_next    = sida_pkg::CH_ZERO + {4'd0, top_digit};
                    last_next    = final_digit;
                    started_next = 1'b1;
                end
                bcd_next = {bcd_reg[BcdW-5:0], 4'd0};
                cnt_next = cnt_reg - CntW'(1);
                if (final_digit)
                begin
                    state_next = sida_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sida_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sida_pkg::BK_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        cnt_reg     <= cnt_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[rtl/signed_int_to_decimal_ascii.sv]
// Signed two's-complement integer to decimal ASCII text, top level.
// Instantiates sida_front, sida_queue, sida_back; depends on sida_pkg.
//
// A command is taken on a rising edge with start high and busy low. Its text
// comes out as a run of characters on char_code, one per strobe cycle, most
// significant first: '-' for negative values, then the digits with leading
// zeros dropped (zero gives a single '0'); last marks the final character.
// Strobe is a one-cycle pulse and cannot be held off, so the receiver must
// take every character in the cycle it appears. Busy is high only while the
// two-entry command queue is full; up to two commands can be waiting while
// one is being converted. Each command passes through the converter's idle
// pop, the bit-serial shift-and-add-3 loop, a sign state for a negative
// value and the digit-by-digit emission scan. Reset clears the back-end state,
// the strobe and the queue pointers and count.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              strobe,
    output logic [7:0]                        char_code,
    output logic                              last
);

    // Decimal digits of 2^(VALUE_BITS-1), the largest magnitude.
    localparam int NumDigits = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

    sida_pkg::q_status_t   q_status;
    logic                  push;
    logic                  push_neg;
    logic [VALUE_BITS-1:0] push_mag;
    logic                  pop;
    logic                  head_neg;
    logic [VALUE_BITS-1:0] head_mag;

    // Front: accept command, form sign and magnitude.
    sida_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .start    (start),
        .value    (value),
        .q_status (q_status),
        .busy     (busy),
        .push     (push),
        .push_neg (push_neg),
        .push_mag (push_mag)
    );

    // Queue decouples command acceptance from conversion.
    sida_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_neg (push_neg),
        .push_mag (push_mag),
        .pop      (pop),
        .q_status (q_status),
        .head_neg (head_neg),
        .head_mag (head_mag)
    );

    // Back: binary to BCD, then at most one character transfer per cycle.
    sida_back #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NumDigits)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_neg  (head_neg),
        .head_mag  (head_mag),
        .pop       (pop),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last)
    );

endmodule

`default_nettype wire

[rtl/sida_checker.sv]
// Port-level checker for signed_int_to_decimal_ascii, with its bind.
// Depends on sida_pkg and signed_int_to_decimal_ascii_macros.svh.
`default_nettype none

`include "signed_int_to_decimal_ascii_macros.svh"

module sida_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       strobe,
    input wire logic [7:0] char_code,
    input wire logic       last
);

    localparam logic [7:0] ChNine = sida_pkg::CH_ZERO + 8'd9;

    logic is_digit;
    logic is_minus;

    assign is_digit = char_code inside {[sida_pkg::CH_ZERO:ChNine]};
    assign is_minus = (char_code == sida_pkg::CH_MINUS);

    // Only '-' or a decimal digit is ever transferred.
    `SIDA_ASSERT_NOW(a_char_legal, strobe, is_minus || is_digit, "illegal character code")

    // A minus sign is never the final character.
    `SIDA_ASSERT_NOW(a_minus_not_last, strobe && is_minus, !last, "run ends on minus sign")

    // Once digits start, they follow back to back with no minus until last.
    `SIDA_ASSERT_NEXT(a_digits_contiguous, strobe && !last && !is_minus, strobe && !is_minus, "gap or minus inside digit run")

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for signed_int_to_decimal_ascii: integers in, decimal ASCII text out.
// Needs only the RTL and sida_pkg. A built-in text predictor checks every character and its
// last flag, with random start gaps and full drain pauses.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS = sida_pkg::VALUE_BITS_DEF;
    // CMD_CYCLES is the worst case per command; the end pause covers a full queue plus slack.
    localparam int CMD_CYCLES = 44;
    localparam int TAIL_CYCLES = 4 * CMD_CYCLES;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_ITEMS = 200;
    localparam int QUIET_TAIL = 40;   // last items are sent with no gaps at all

    // One character of expected text.
    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } text_char_t;

    // One planned command: the integer, the idle gap after the previous transfer,
    // and whether to hold off until all outstanding text has come back.
    typedef struct {
        logic signed [VALUE_BITS-1:0] num;
        int                           gap;
        bit                           drain;
    } plan_item_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic signed [VALUE_BITS-1:0] value = '0;
    logic                         busy;
    logic                         strobe;
    logic [7:0]                   char_code;
    logic                         last;

    plan_item_t pending_cmds[$];
    text_char_t expected_text[$];

    int idle_left = 0;
    int items_sent = 0;
    int neg_items = 0;
    int chars_checked = 0;
    int error_count = 0;
    int cycle_count = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .strobe   (strobe),
        .char_code(char_code),
        .last     (last)
    );

    always #2 clk = ~clk;

    // Watchdog: a hung block or a lost strobe ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, expected_text.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic flag_error(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Decimal text of a two's-complement integer. The magnitude is formed as an
    // unsigned VALUE_BITS-bit number, so the most negative value needs no extra bit.
    function automatic void predict_text(input logic signed [VALUE_BITS-1:0] num);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits[$];
        text_char_t            ch;
        mag = num[VALUE_BITS-1] ? (~num + 1'b1) : num;
        do
        begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (num[VALUE_BITS-1])
        begin
            ch.code = sida_pkg::CH_MINUS;
            ch.is_last = 1'b0;
            expected_text.push_back(ch);
        end
        foreach (digits[i])
        begin
            ch.code = sida_pkg::CH_ZERO + 8'(digits[i]);
            ch.is_last = (i == digits.size() - 1);
            expected_text.push_back(ch);
        end
    endfunction

    // Driver: a transfer happens at an edge with start high and busy low. The
    // predictor runs on that edge; the next command (or an idle cycle) is set up
    // in the same step, so start is written at most once per edge.
    always @(posedge clk)
    begin
        plan_item_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                predict_text(value);
                items_sent++;
                if (value[VALUE_BITS-1])
                    neg_items++;
            end
            if (idle_left != 0)
            begin
                idle_left--;
                start <= 1'b0;
                value <= $urandom;  // ignored while start is low
            end
            else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && expected_text.size() != 0))
            begin
                nxt = pending_cmds.pop_front();
                start <= 1'b1;
                value <= nxt.num;
                if (pending_cmds.size() != 0)
                    idle_left = pending_cmds[0].gap;
            end
            else
            begin
                start <= 1'b0;
                value <= $urandom;
            end
        end
    end

    // Monitor: strobe cannot be held off, so every strobed cycle is one character.
    always @(posedge clk)
    begin
        text_char_t exp_ch;
        if (rst_n && strobe)
        begin
            if (expected_text.size() == 0)
            begin
                flag_error($sformatf("unexpected character 0x%02h last=%0b", char_code, last));
            end
            else
            begin
                exp_ch = expected_text.pop_front();
                chars_checked++;
                if (char_code !== exp_ch.code)
                    flag_error($sformatf("char_code got 0x%02h expected 0x%02h",
                                         char_code, exp_ch.code));
                if (last !== exp_ch.is_last)
                    flag_error($sformatf("last got %0b expected %0b (char 0x%02h)",
                                         last, exp_ch.is_last, exp_ch.code));
            end
        end
    end

    task automatic plan(input logic signed [VALUE_BITS-1:0] num, input int gap, input bit drain);
        plan_item_t it;
        it.num = num;
        it.gap = gap;
        it.drain = drain;
        pending_cmds.push_back(it);
    endtask

    initial
    begin
        logic signed [VALUE_BITS-1:0] num;
        bit                           gaps_on;
        int                           gap;

        // Directed: zero, one-digit edges, digit-count boundaries, and both extremes.
        // The most negative value checks the no-overflow magnitude path.
        plan(0, 0, 1'b0);
        plan(1, 0, 1'b0);
        plan(-1, 0, 1'b0);
        plan(9, 0, 1'b0);
        plan(10, 3, 1'b0);
        plan(-10, 0, 1'b0);
        plan(99, 0, 1'b0);
        plan(100, 1, 1'b0);
        plan(-5, 0, 1'b0);
        plan(32'sh7FFF_FFFF, 0, 1'b0);
        plan(32'sh8000_0000, 0, 1'b0);
        plan(32'sh8000_0001, 0, 1'b0);
        plan(999_999_999, 0, 1'b0);
        plan(1_000_000_000, 0, 1'b0);
        plan(-999_999_999, 7, 1'b0);
        plan(-1_000_000_000, 0, 1'b0);
        plan(1_000_000_001, 0, 1'b0);
        plan(12345, 0, 1'b0);
        plan(-67890, 0, 1'b0);
        plan(32'sh5555_5555, 0, 1'b0);
        plan(32'shAAAA_AAAA, 0, 1'b0);

        // Random part in blocks of 20, each block with or without idle bursts.
        // Magnitudes are spread over all digit counts by a random right shift.
        gaps_on = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 20 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 3))
                0: num = $urandom;
                1: num = $urandom_range(0, 99);
                default: num = $urandom >> $urandom_range(0, 31);
            endcase
            if ($urandom_range(0, 1) == 1)
                num = -num;
            gap = 0;
            if (gaps_on && i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 16);
            // Full drain before the first random command and now and then afterwards.
            plan(num, gap, (i == 0) || ($urandom_range(0, 39) == 0));
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        while (expected_text.size() != 0)
            @(posedge clk);
        // Quiet window catches any stray characters after the last run.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d integers (%0d negative, both extremes), %0d characters checked",
                 items_sent, neg_items, chars_checked);
        $display("random start gaps and drain pauses were applied; %0d mismatches", error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/sida_pkg.sv
rtl/sida_front.sv
rtl/sida_queue.sv
rtl/sida_back.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/sida_checker.sv
dv/testbench.sv
